@@ rtl/ppsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppsd_pkg
// shared types and constants for the p6 stream decoder
// ----------------------------------------------------------------------------
package ppsd_pkg;

    localparam int unsigned MAX_DIM = 4096;
    localparam int unsigned ACC_CAP = (MAX_DIM > 255) ? MAX_DIM + 1 : 256;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_NUMBER    = 3'd2;
    localparam logic [2:0] ERR_MAXVAL    = 3'd3;
    localparam logic [2:0] ERR_ZERO_SIZE = 3'd4;
    localparam logic [2:0] ERR_SEPARATOR = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd7;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [12:0] MAXVAL_OK = 13'd255;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       is_blank;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_hash;
        logic       is_nl;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] col;
        logic [11:0] row;
        logic [12:0] width;
        logic [12:0] height;
        logic [2:0]  err;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       item0;
        res_t       item1;
    } res_wr_t;

endpackage

@@ rtl/ppsd_front.sv @@
// ----------------------------------------------------------------------------
// ppsd_front
// byte intake: classifies each byte and writes it to the command queue
// ----------------------------------------------------------------------------
module ppsd_front
    import ppsd_pkg::*;
(
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       q_wr,
    output cmd_t       q_data
);

    always_comb
    begin
        q_data.byte_val = in_byte;
        q_data.last     = in_last;
        q_data.is_blank = (in_byte == CH_SPACE) || (in_byte inside {[8'd9:8'd13]});
        q_data.is_digit = in_byte inside {[CH_ZERO:CH_NINE]};
        q_data.digit    = 4'(in_byte - CH_ZERO);
        q_data.is_hash  = (in_byte == CH_HASH);
        q_data.is_nl    = (in_byte == CH_NL);
    end

    assign full = q_full;
    assign q_wr = push && !q_full;

endmodule

@@ rtl/ppsd_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// ppsd_cmd_queue
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module ppsd_cmd_queue
    import ppsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd,
    output logic valid,
    output cmd_t rd_data
);

    cmd_t       slot_reg [QUEUE_DEPTH];
    logic [1:0] wptr_reg;
    logic [1:0] rptr_reg;
    logic [2:0] count_reg;
    logic       rd_fire;

    assign full    = (count_reg == 3'(QUEUE_DEPTH));
    assign valid   = (count_reg != 3'd0);
    assign rd_fire = rd && valid;
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
                wptr_reg <= wptr_reg + 2'd1;
            if (rd_fire)
                rptr_reg <= rptr_reg + 2'd1;
            count_reg <= count_reg + {2'b0, wr} - {2'b0, rd_fire};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wptr_reg] <= wr_data;
    end

endmodule

@@ rtl/ppsd_back.sv @@
// ----------------------------------------------------------------------------
// ppsd_back
// header parser and pixel grouper, up to two results per byte
// ----------------------------------------------------------------------------
module ppsd_back
    import ppsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_rd,
    input  logic    space_ok,
    output res_wr_t res_wr
);

    typedef enum logic [3:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_BLANK,
        PH_COMMENT,
        PH_NUMBER,
        PH_PIXELS,
        PH_TRAIL,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [12:0] acc_reg, acc_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [1:0]  ch_reg, ch_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;

    logic        step;
    logic [16:0] acc_sum;
    res_t        slot0, slot1;
    logic [1:0]  n;
    logic        do_blank;
    logic        do_fail;
    logic [2:0]  fcode;
    logic        pix_v;
    logic        done_v;

    assign step   = cmd_valid && space_ok;
    assign cmd_rd = step;
    assign acc_sum = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0} + {13'b0, cmd.digit};

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ch_next     = ch_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        do_blank    = 1'b0;
        do_fail     = 1'b0;
        fcode       = ERR_NONE;
        pix_v       = 1'b0;
        done_v      = 1'b0;
        slot0       = '0;
        slot1       = '0;
        n           = 2'd0;

        case (phase_reg)
            PH_MAGIC0:
            begin
                if (cmd.byte_val == CH_P)
                    phase_next = PH_MAGIC1;
                else
                begin
                    do_fail = 1'b1;
                    fcode   = ERR_MAGIC;
                end
            end
            PH_MAGIC1:
            begin
                if (cmd.byte_val == CH_SIX)
                    phase_next = PH_BLANK;
                else
                begin
                    do_fail = 1'b1;
                    fcode   = ERR_MAGIC;
                end
            end
            PH_BLANK:
            begin
                do_blank = 1'b1;
            end
            PH_COMMENT:
            begin
                if (cmd.is_nl)
                    phase_next = PH_BLANK;
            end
            PH_NUMBER:
            begin
                if (cmd.is_digit)
                begin
                    if (acc_sum > 17'(ACC_CAP))
                        acc_next = 13'(ACC_CAP);
                    else
                        acc_next = acc_sum[12:0];
                end
                else if (idx_reg < 2'd2)
                begin
                    if (idx_reg == 2'd0)
                        width_next = acc_reg;
                    else
                        height_next = acc_reg;
                    if (acc_reg > 13'(MAX_DIM))
                    begin
                        do_fail = 1'b1;
                        fcode   = ERR_TOO_LARGE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                        acc_next = '0;
                        do_blank = 1'b1;
                    end
                end
                else if (acc_reg != MAXVAL_OK)
                begin
                    do_fail = 1'b1;
                    fcode   = ERR_MAXVAL;
                end
                else if (width_reg == '0 || height_reg == '0)
                begin
                    do_fail = 1'b1;
                    fcode   = ERR_ZERO_SIZE;
                end
                else if (!cmd.is_blank)
                begin
                    do_fail = 1'b1;
                    fcode   = ERR_SEPARATOR;
                end
                else
                begin
                    phase_next = PH_PIXELS;
                    col_next   = '0;
                    row_next   = '0;
                    ch_next    = '0;
                end
            end
            PH_PIXELS:
            begin
                if (ch_reg == 2'd0)
                begin
                    red_next = cmd.byte_val;
                    ch_next  = 2'd1;
                end
                else if (ch_reg == 2'd1)
                begin
                    green_next = cmd.byte_val;
                    ch_next    = 2'd2;
                end
                else
                begin
                    ch_next = 2'd0;
                    pix_v   = 1'b1;
                    if ({1'b0, col_reg} + 13'd1 >= width_reg)
                    begin
                        col_next = '0;
                        if ({1'b0, row_reg} + 13'd1 >= height_reg)
                        begin
                            phase_next = PH_TRAIL;
                            done_v     = 1'b1;
                        end
                        else
                            row_next = row_reg + 12'd1;
                    end
                    else
                        col_next = col_reg + 12'd1;
                end
            end
            default:
            begin
            end
        endcase

        // whitespace, comment start or number start, any other byte is a number error
        if (do_blank)
        begin
            if (cmd.is_blank)
                phase_next = PH_BLANK;
            else if (cmd.is_hash)
                phase_next = PH_COMMENT;
            else if (cmd.is_digit)
            begin
                acc_next   = {9'b0, cmd.digit};
                phase_next = PH_NUMBER;
            end
            else
            begin
                do_fail = 1'b1;
                fcode   = ERR_NUMBER;
            end
        end

        if (do_fail)
        begin
            phase_next = PH_ERROR;
            slot0.kind = KIND_ERROR;
            slot0.err  = fcode;
            n          = 2'd1;
        end

        if (pix_v)
        begin
            slot0.kind  = KIND_PIXEL;
            slot0.red   = red_reg;
            slot0.green = green_reg;
            slot0.blue  = cmd.byte_val;
            slot0.col   = col_reg;
            slot0.row   = row_reg;
            n           = 2'd1;
            if (done_v)
            begin
                slot1.kind = KIND_DONE;
                n          = 2'd2;
            end
        end

        // end mark before a finished image
        if (cmd.last && phase_next != PH_TRAIL && phase_next != PH_ERROR)
        begin
            if (n == 2'd0)
            begin
                slot0.kind = KIND_ERROR;
                slot0.err  = ERR_TRUNCATED;
            end
            else
            begin
                slot1.kind = KIND_ERROR;
                slot1.err  = ERR_TRUNCATED;
            end
            n = n + 2'd1;
        end

        slot0.width  = width_next;
        slot0.height = height_next;
        slot1.width  = width_next;
        slot1.height = height_next;
        slot0.last   = (n == 2'd1);
        slot1.last   = (n == 2'd2);

        if (cmd.last)
        begin
            phase_next  = PH_MAGIC0;
            idx_next    = '0;
            acc_next    = '0;
            width_next  = '0;
            height_next = '0;
            col_next    = '0;
            row_next    = '0;
            ch_next     = '0;
            red_next    = '0;
            green_next  = '0;
        end
    end

    assign res_wr.cnt   = step ? n : 2'd0;
    assign res_wr.item0 = slot0;
    assign res_wr.item1 = slot1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC0;
            idx_reg    <= '0;
            acc_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            ch_reg     <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ch_reg     <= ch_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
        end
    end

endmodule

@@ rtl/ppsd_res_queue.sv @@
// ----------------------------------------------------------------------------
// ppsd_res_queue
// result queue, takes up to two results per cycle and hands out one
// ----------------------------------------------------------------------------
module ppsd_res_queue
    import ppsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  res_wr_t wr,
    output logic    space_ok,
    input  logic    pop,
    output logic    empty,
    output res_t    head
);

    res_t       slot_reg [QUEUE_DEPTH];
    logic [1:0] wptr_reg;
    logic [1:0] rptr_reg;
    logic [2:0] count_reg;
    logic       pop_fire;

    assign empty    = (count_reg == 3'd0);
    assign space_ok = (count_reg <= 3'(QUEUE_DEPTH - 2));
    assign pop_fire = pop && !empty;
    assign head     = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + wr.cnt;
            if (pop_fire)
                rptr_reg <= rptr_reg + 2'd1;
            count_reg <= count_reg + {1'b0, wr.cnt} - {2'b0, pop_fire};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.cnt != 2'd0)
            slot_reg[wptr_reg] <= wr.item0;
        if (wr.cnt == 2'd2)
            slot_reg[wptr_reg + 2'd1] <= wr.item1;
    end

endmodule

@@ rtl/ppm_p6_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder_top
// binary ppm (p6) stream decoder: header parse, pixel grouping, status
//
//   channel   direction  handshake         payload
//   bytes     in         push / full       in_byte, in_last
//   results   out        pop / empty       out_kind .. out_last
//
// one byte per cycle while full is low; a byte is registered in the command queue,
// its results then in the result queue, before they show on the ports
// the back parser steps only when the result queue has two free slots
// reset clears both queues and the parser state, no clearing pass
// a stalled result side fills the queues and then raises full
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder_top
    import ppsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  out_kind,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [11:0] pix_col,
    output logic [11:0] pix_row,
    output logic [12:0] img_width,
    output logic [12:0] img_height,
    output logic [2:0]  err_code,
    output logic        out_last
);

    logic    q_full;
    logic    q_wr;
    cmd_t    q_wdata;
    logic    q_valid;
    cmd_t    q_rdata;
    logic    q_rd;
    logic    space_ok;
    res_wr_t res_wr;
    res_t    head;

    ppsd_front u_front (
        .push    (push),
        .full    (full),
        .in_byte (in_byte),
        .in_last (in_last),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_data  (q_wdata)
    );

    ppsd_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd      (q_rd),
        .valid   (q_valid),
        .rd_data (q_rdata)
    );

    ppsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_rdata),
        .cmd_rd    (q_rd),
        .space_ok  (space_ok),
        .res_wr    (res_wr)
    );

    ppsd_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (res_wr),
        .space_ok (space_ok),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    assign out_kind   = head.kind;
    assign red        = head.red;
    assign green      = head.green;
    assign blue       = head.blue;
    assign pix_col    = head.col;
    assign pix_row    = head.row;
    assign img_width  = head.width;
    assign img_height = head.height;
    assign err_code   = head.err;
    assign out_last   = head.last;

endmodule

@@ rtl/ppsd_checker.sv @@
// ----------------------------------------------------------------------------
// ppsd_checker
// port-level checks on the decoder result stream
// ----------------------------------------------------------------------------
module ppsd_checker
    import ppsd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  out_kind,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic [11:0] pix_col,
    input logic [11:0] pix_row,
    input logic [12:0] img_width,
    input logic [12:0] img_height,
    input logic [2:0]  err_code,
    input logic        out_last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(err_code)
                              && $stable(out_last)))
        else $error("stalled result changed");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == KIND_ERROR) |->
            (err_code != ERR_NONE && red == 8'd0 && pix_col == 12'd0 && pix_row == 12'd0))
        else $error("error result with bad fields");

    a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind != KIND_ERROR) |-> (err_code == ERR_NONE && out_kind < KIND_ERROR))
        else $error("non-error result carries a code");

    a_pixel_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == KIND_PIXEL) |->
            ({1'b0, pix_col} < img_width && {1'b0, pix_row} < img_height))
        else $error("pixel outside image");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == KIND_DONE) |->
            (green == 8'd0 && blue == 8'd0 && img_width != 13'd0 && img_height != 13'd0))
        else $error("bad image complete result");

endmodule

bind ppm_p6_stream_decoder_top ppsd_checker u_ppsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .out_kind   (out_kind),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .pix_col    (pix_col),
    .pix_row    (pix_row),
    .img_width  (img_width),
    .img_height (img_height),
    .err_code   (err_code),
    .out_last   (out_last)
);

@@ dv/ppm_p6_stream_decoder_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder_top_test
// self-checking bench for the p6 stream decoder: byte files in, pixels and
// status out, every result compared against a behavioral decoder kept here
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder_top_test;
    import ppsd_pkg::*;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [2:0] {
        ST_MAGIC_P,
        ST_MAGIC_6,
        ST_GAP,
        ST_COMMENT,
        ST_DIGITS,
        ST_PIXELS,
        ST_TRAIL,
        ST_ERROR
    } parse_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] pix_col;
    logic [11:0] pix_row;
    logic [12:0] img_width;
    logic [12:0] img_height;
    logic [2:0]  err_code;
    logic        out_last;

    // decoder state mirrored by the bench
    parse_state_t pstate = ST_MAGIC_P;
    int unsigned  num_idx;
    int unsigned  acc;
    int unsigned  width_q;
    int unsigned  height_q;
    int unsigned  col_q;
    int unsigned  row_q;
    int unsigned  chan_q;
    logic [7:0]   red_q;
    logic [7:0]   green_q;

    res_t         step_res [2];
    int           step_cnt;
    res_t         pending_results [$];
    logic [7:0]   file_bytes [$];

    int           error_count = 0;
    int           sent_items = 0;
    bit           send_idle_on = 1'b1;
    bit           pop_idle_on = 1'b1;
    int           hold_requests = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    ppm_p6_stream_decoder_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .empty      (empty),
        .pop        (pop),
        .out_kind   (out_kind),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .pix_col    (pix_col),
        .pix_row    (pix_row),
        .img_width  (img_width),
        .img_height (img_height),
        .err_code   (err_code),
        .out_last   (out_last)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // behavioral decoder
    // ------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_CR ||
               b == CH_VT || b == CH_FF;
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void clear_parser();
        pstate   = ST_MAGIC_P;
        num_idx  = 0;
        acc      = 0;
        width_q  = 0;
        height_q = 0;
        col_q    = 0;
        row_q    = 0;
        chan_q   = 0;
        red_q    = 8'h00;
        green_q  = 8'h00;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b, int unsigned col, int unsigned row,
                                       logic [2:0] err);
        res_t item;
        item.kind   = kind;
        item.red    = r;
        item.green  = g;
        item.blue   = b;
        item.col    = col[11:0];
        item.row    = row[11:0];
        item.width  = width_q[12:0];
        item.height = height_q[12:0];
        item.err    = err;
        item.last   = 1'b0;
        step_res[step_cnt] = item;
        step_cnt++;
    endfunction

    function automatic void raise_error(logic [2:0] err);
        pstate = ST_ERROR;
        add_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, 0, 0, err);
    endfunction

    function automatic void gap_byte(logic [7:0] b);
        if (is_space(b))
            pstate = ST_GAP;
        else if (b == CH_HASH)
            pstate = ST_COMMENT;
        else if (is_num(b))
        begin
            acc    = 32'(b - CH_ZERO);
            pstate = ST_DIGITS;
        end
        else
            raise_error(ERR_NUMBER);
    endfunction

    function automatic void close_number(logic [7:0] b);
        if (num_idx < 2)
        begin
            if (num_idx == 0)
                width_q = acc;
            else
                height_q = acc;
            if (acc > MAX_DIM)
            begin
                raise_error(ERR_TOO_LARGE);
                return;
            end
            num_idx++;
            acc = 0;
            gap_byte(b);
            return;
        end
        if (acc != 32'(MAXVAL_OK))
            raise_error(ERR_MAXVAL);
        else if (width_q == 0 || height_q == 0)
            raise_error(ERR_ZERO_SIZE);
        else if (!is_space(b))
            raise_error(ERR_SEPARATOR);
        else
        begin
            pstate = ST_PIXELS;
            col_q  = 0;
            row_q  = 0;
            chan_q = 0;
        end
    endfunction

    function automatic void take_channel(logic [7:0] b);
        if (chan_q == 0)
        begin
            red_q  = b;
            chan_q = 1;
            return;
        end
        if (chan_q == 1)
        begin
            green_q = b;
            chan_q  = 2;
            return;
        end
        chan_q = 0;
        add_result(KIND_PIXEL, red_q, green_q, b, col_q, row_q, ERR_NONE);
        if (col_q + 1 >= width_q)
        begin
            col_q = 0;
            if (row_q + 1 >= height_q)
            begin
                pstate = ST_TRAIL;
                add_result(KIND_DONE, 8'h00, 8'h00, 8'h00, 0, 0, ERR_NONE);
            end
            else
                row_q++;
        end
        else
            col_q++;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic l);
        step_cnt = 0;
        case (pstate)
            ST_MAGIC_P:
                if (b == CH_P)
                    pstate = ST_MAGIC_6;
                else
                    raise_error(ERR_MAGIC);
            ST_MAGIC_6:
                if (b == CH_SIX)
                    pstate = ST_GAP;
                else
                    raise_error(ERR_MAGIC);
            ST_GAP:
                gap_byte(b);
            ST_COMMENT:
                if (b == CH_NL)
                    pstate = ST_GAP;
            ST_DIGITS:
                if (is_num(b))
                begin
                    acc = acc * 10 + 32'(b - CH_ZERO);
                    if (acc > ACC_CAP)
                        acc = ACC_CAP;
                end
                else
                    close_number(b);
            ST_PIXELS:
                take_channel(b);
            default:
                ;
        endcase
        if (l)
        begin
            if (pstate != ST_TRAIL && pstate != ST_ERROR)
                add_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, 0, 0, ERR_TRUNCATED);
            clear_parser();
        end
        for (int i = 0; i < step_cnt; i++)
        begin
            if (i == step_cnt - 1)
                step_res[i].last = 1'b1;
            pending_results.insert(pending_results.size(), step_res[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [12:0] got,
                               input logic [12:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no transfer waiting for it");
            else
            begin
                want = pending_results.pop_front();
                check_field("out_kind", 13'(out_kind), 13'(want.kind));
                check_field("red", 13'(red), 13'(want.red));
                check_field("green", 13'(green), 13'(want.green));
                check_field("blue", 13'(blue), 13'(want.blue));
                check_field("pix_col", 13'(pix_col), 13'(want.col));
                check_field("pix_row", 13'(pix_row), 13'(want.row));
                check_field("img_width", img_width, want.width);
                check_field("img_height", img_height, want.height);
                check_field("err_code", 13'(err_code), 13'(want.err));
                check_field("out_last", 13'(out_last), 13'(want.last));
            end
        end
    end

    // result side: random stalls plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = 120;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= !(pop_idle_on && $urandom_range(99) < 24);
    end

    // ------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic l);
        @(negedge clk);
        while (send_idle_on && $urandom_range(99) < 24)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        in_last <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_items++;
        decode_byte(b, l);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    function automatic void add_byte(logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] space_byte();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NL;
            3: return CH_CR;
            4: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] bad_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_space(b) || is_num(b) || b == CH_HASH)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic logic [7:0] other_than(logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == avoid)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic logic [7:0] pixel_value();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic void put_gap(int min_len);
        int n;
        int k;
        logic [7:0] b;
        n = $urandom_range(3, min_len);
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
            begin
                add_byte(CH_HASH);
                k = $urandom_range(4);
                repeat (k)
                begin
                    b = 8'($urandom_range(255));
                    add_byte(b == CH_NL ? CH_SPACE : b);
                end
                add_byte(CH_NL);
            end
            else
                add_byte(space_byte());
        end
    endfunction

    function automatic void put_number(int unsigned v);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(2, 1))
                add_byte(CH_ZERO);
        put_text($sformatf("%0d", v));
    endfunction

    function automatic int unsigned big_number();
        case ($urandom_range(2))
            0: return MAX_DIM + 1;
            1: return $urandom_range(65535, MAX_DIM + 1);
            default: return 99999999;
        endcase
    endfunction

    // well-formed files with random content, some with a single fault, some plain random bytes
    function automatic void build_file();
        int f;
        int w;
        int h;
        int miss;
        int unsigned mv;
        file_bytes.delete();
        f = $urandom_range(19);
        if (f == 9)
        begin
            repeat ($urandom_range(20, 1))
                add_byte(8'($urandom_range(255)));
            return;
        end
        w    = $urandom_range(6, 1);
        h    = $urandom_range(4, 1);
        miss = $urandom_range(2);
        add_byte(f == 0 ? other_than(CH_P) : CH_P);
        add_byte(f == 1 ? other_than(CH_SIX) : CH_SIX);
        put_gap(0);
        if (f == 2 && miss == 0)
            add_byte(bad_byte());
        else
            put_number(f == 3 ? big_number() : (f == 6 && miss == 0) ? 0 : w);
        put_gap(1);
        if (f == 2 && miss == 1)
            add_byte(bad_byte());
        else
            put_number(f == 4 ? big_number() : (f == 6 && miss != 0) ? 0 : h);
        put_gap(1);
        if (f == 2 && miss == 2)
            add_byte(bad_byte());
        else if (f == 5)
        begin
            mv = $urandom_range(70000);
            put_number(mv == 32'(MAXVAL_OK) ? 0 : mv);
        end
        else
            put_number(32'(MAXVAL_OK));
        if (f == 7)
            add_byte($urandom_range(1) ? CH_HASH : bad_byte());
        else
            add_byte(space_byte());
        repeat (w * h * 3)
            add_byte(pixel_value());
        if (f == 10)
            repeat ($urandom_range(5, 1))
                add_byte(8'($urandom_range(255)));
        if (f == 8)
        begin
            mv = $urandom_range(file_bytes.size() - 1, 1);
            while (file_bytes.size() > mv)
                void'(file_bytes.pop_back());
        end
    endfunction

    // header for w by h, then npix pixels; fewer than w * h ends truncated
    function automatic void build_image(int w, int h, int npix);
        file_bytes.delete();
        add_byte(CH_P);
        add_byte(CH_SIX);
        add_byte(CH_SPACE);
        put_text($sformatf("%0d", w));
        add_byte(CH_SPACE);
        put_text($sformatf("%0d", h));
        add_byte(CH_SPACE);
        put_text("255");
        add_byte(CH_NL);
        repeat (npix * 3)
            add_byte(pixel_value());
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_bad_magic();
        send_byte(8'h58, 1'b1);
        send_byte(CH_P, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_single_pixel();
        file_bytes.delete();
        add_byte(CH_P);
        add_byte(CH_SIX);
        add_byte(CH_FF);
        add_byte(CH_HASH);
        add_byte(8'h78);
        add_byte(CH_NL);
        put_text("1");
        add_byte(CH_TAB);
        put_text("1");
        add_byte(CH_CR);
        put_text("255");
        add_byte(CH_VT);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'hA5);
        add_byte(8'h80);
        send_file();
    endtask

    task automatic test_widest_image();
        build_image(MAX_DIM, 1, 3);
        send_file();
    endtask

    task automatic test_tallest_image();
        build_image(1, MAX_DIM, 3);
        send_file();
    endtask

    task automatic test_backpressure();
        send_idle_on = 1'b0;
        hold_requests++;
        build_image(5, 4, 20);
        send_file();
        send_idle_on = 1'b1;
    endtask

    task automatic test_streaming();
        send_idle_on = 1'b0;
        pop_idle_on  = 1'b0;
        repeat (3)
        begin
            build_file();
            send_file();
        end
        send_idle_on = 1'b1;
        pop_idle_on  = 1'b1;
    endtask

    task automatic test_random_files();
        while (sent_items < 400)
        begin
            build_file();
            send_file();
        end
    endtask

    task automatic finish_run();
        @(negedge clk);
        push    <= 1'b0;
        in_last <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    endtask

    initial
    begin
        clear_parser();
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_bad_magic();
        test_single_pixel();
        test_backpressure();
        test_streaming();
        test_widest_image();
        test_tallest_image();
        test_random_files();
        finish_run();
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
